// ===== hdl/ascii_integer_stream_parser_macros.svh =====
// ----------------------------------------------------------------------------
// ascii integer stream parser assertion macros
// concurrent assertion shorthands, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_STREAM_PARSER_MACROS_SVH
`define ASCII_INTEGER_STREAM_PARSER_MACROS_SVH

// same-cycle implication
`define AISP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aisp assertion failed");

// next-cycle implication
`define AISP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aisp assertion failed");

`endif

// ===== hdl/aisp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_pkg
// shared types and character constants of the ascii integer stream parser
// ----------------------------------------------------------------------------
package aisp_pkg;

    localparam int AISP_VALUE_WIDTH = 64;
    localparam int OUT_WIDTH        = 64;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_LOW_X = 8'h78;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_MID  = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_OCT  = 3'd4;
    localparam logic [2:0] PH_DEC  = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] parsed_value;
        logic [1:0]           base_used;
        logic                 was_negative;
    } result_t;

endpackage

// ===== hdl/aisp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_in_stage
// input register holding one character item until the parser takes it
// ----------------------------------------------------------------------------
module aisp_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  aisp_pkg::item_t s_item,
    input  logic            advance,
    output logic            item_valid,
    output aisp_pkg::item_t item
);
    import aisp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hdl/aisp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_parser
// parse state, base detection, shift-add accumulation, 1 char/cycle on advance
// ----------------------------------------------------------------------------
module aisp_parser #(
    parameter int VALUE_WIDTH = aisp_pkg::AISP_VALUE_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  aisp_pkg::item_t   item,
    input  logic              signed_mode,
    output aisp_pkg::result_t result
);
    import aisp_pkg::*;

    logic [2:0]             phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    // negated accumulator kept alongside, so negation costs no extra adder
    logic [VALUE_WIDTH-1:0] nacc_reg, nacc_next;
    logic                   minus_reg, minus_next;
    logic [1:0]             base_reg, base_next;

    logic [7:0]             c;
    logic                   is_blank, is_minus, is_x, is_dec, is_oct, is_hex;
    logic [3:0]             hex_val;
    logic [VALUE_WIDTH-1:0] dig;
    logic                   start_num;
    logic                   neg;

    always_comb
    begin
        c        = item.char_code;
        is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
        is_minus = (c == CHAR_MINUS);
        is_x     = (c == CHAR_LOW_X) || (c == CHAR_UP_X);
        is_dec   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_oct   = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
        is_hex   = is_dec || ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_F))
                   || ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
        hex_val  = is_dec ? c[3:0] : c[3:0] + 4'd9;
        dig      = {{(VALUE_WIDTH-4){1'b0}}, hex_val};

        phase_next = phase_reg;
        acc_next   = acc_reg;
        nacc_next  = nacc_reg;
        minus_next = minus_reg;
        base_next  = base_reg;
        start_num  = 1'b0;

        case (phase_reg)
            PH_LEAD:
            begin
                if (!is_blank)
                begin
                    if (is_minus)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_MID;
                    end
                    else
                    begin
                        start_num = 1'b1;
                    end
                end
            end
            PH_MID:
            begin
                if (!is_blank)
                begin
                    start_num = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (is_x)
                begin
                    phase_next = PH_HEX;
                    base_next  = BASE_HEX;
                end
                else if (is_oct)
                begin
                    phase_next = PH_OCT;
                    acc_next   = dig;
                    nacc_next  = '0 - dig;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_HEX:
            begin
                if (is_hex)
                begin
                    acc_next  = (acc_reg << 4) + dig;
                    nacc_next = (nacc_reg << 4) - dig;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_OCT:
            begin
                if (is_oct)
                begin
                    acc_next  = (acc_reg << 3) + dig;
                    nacc_next = (nacc_reg << 3) - dig;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DEC:
            begin
                if (is_dec)
                begin
                    acc_next  = (acc_reg << 3) + (acc_reg << 1) + dig;
                    nacc_next = (nacc_reg << 3) + (nacc_reg << 1) - dig;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (start_num)
        begin
            if (c == CHAR_ZERO)
            begin
                phase_next = PH_ZERO;
                base_next  = BASE_OCT;
            end
            else if ((c >= CHAR_ONE) && (c <= CHAR_NINE))
            begin
                phase_next = PH_DEC;
                acc_next   = dig;
                nacc_next  = '0 - dig;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        neg                 = signed_mode && minus_next;
        result.parsed_value = '0;
        result.parsed_value[VALUE_WIDTH-1:0] = neg ? nacc_next : acc_next;
        result.base_used    = base_next;
        result.was_negative = neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            nacc_reg  <= '0;
            minus_reg <= 1'b0;
            base_reg  <= BASE_DEC;
        end
        else if (advance)
        begin
            if (item.last_char)
            begin
                phase_reg <= PH_LEAD;
                acc_reg   <= '0;
                nacc_reg  <= '0;
                minus_reg <= 1'b0;
                base_reg  <= BASE_DEC;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                nacc_reg  <= nacc_next;
                minus_reg <= minus_next;
                base_reg  <= base_next;
            end
        end
    end

endmodule

// ===== hdl/aisp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_out_stage
// result register on the master side, holds a result until it is taken
// ----------------------------------------------------------------------------
module aisp_out_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  aisp_pkg::result_t                  result,
    output logic                               load_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [aisp_pkg::OUT_WIDTH-1:0]     m_tdata,
    output logic [2:0]                         m_tuser
);
    import aisp_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign load_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_tdata    = result_reg.parsed_value;
    assign m_tuser    = {result_reg.was_negative, result_reg.base_used};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== hdl/ascii_integer_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_stream_parser
// streams ascii characters in, gives one parsed integer per string
// ----------------------------------------------------------------------------
// One character item is accepted every clock cycle, with no gaps between
// strings, except while the input stalls as described below; the shift-add
// accumulator takes one digit per cycle while characters advance. The result
// of a string reaches the master side through the input register, then the
// result register. The input stalls only when a result waits in the result
// register and the next last character arrives behind it. Leading blanks, an
// optional minus, 0x/0X hex, leading-zero octal and decimal are handled.
// ----------------------------------------------------------------------------
module ascii_integer_stream_parser #(
    parameter int VALUE_WIDTH = aisp_pkg::AISP_VALUE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,  // signed_mode
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,      // char_code
    input  logic                           s_tlast,      // last_char
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [aisp_pkg::OUT_WIDTH-1:0] m_tdata,      // parsed_value
    output logic [2:0]                     m_tuser       // base_used, was_negative
);
    import aisp_pkg::*;

    logic    signed_mode_reg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    out_ready;
    result_t result;

    assign s_item.char_code = s_tdata;
    assign s_item.last_char = s_tlast;
    assign advance          = item_valid && (!item.last_char || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            signed_mode_reg <= cfg_wr_data;
        end
    end

    aisp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    aisp_parser #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item),
        .signed_mode (signed_mode_reg),
        .result      (result)
    );

    aisp_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && item.last_char),
        .result     (result),
        .load_ready (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== hdl/aisp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisp_checker
// port-level checks of the ascii integer stream parser, bound to the top level
// ----------------------------------------------------------------------------
`include "ascii_integer_stream_parser_macros.svh"

module aisp_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [aisp_pkg::OUT_WIDTH-1:0] m_tdata,
    input logic [2:0]                     m_tuser
);
    import aisp_pkg::*;

    // stalled result holds
    `AISP_ASSERT_NEXT(out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // input stalls only behind a waiting result
    `AISP_ASSERT_IMPL(in_stall_cause, !s_tready, m_tvalid && !m_tready)

    // a fresh result follows an accepted last item
    `AISP_ASSERT_IMPL(out_follows_last, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast, 2))

    // base code is one of the three bases
    `AISP_ASSERT_IMPL(base_known, m_tvalid, m_tuser[1:0] == BASE_DEC || m_tuser[1:0] == BASE_OCT || m_tuser[1:0] == BASE_HEX)

endmodule

bind ascii_integer_stream_parser aisp_checker u_aisp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_ascii_integer_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_integer_stream_parser
// streams directed and random character strings into the parser, runs its
// own parse of every accepted character and checks each parsed value, base
// and sign flag in order, with random stalls on both sides and a long
// receiver hold-off, under both settings of signed mode
// ----------------------------------------------------------------------------
module tb_ascii_integer_stream_parser;

    import aisp_pkg::*;

    localparam int          CLK_HALF     = 1;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_ITEMS  = 190;
    localparam int          SETTLE       = 8;
    localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - AISP_VALUE_WIDTH);

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = 8'd0;   // char_code
    logic                 s_tlast     = 1'b0;   // last_char
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [OUT_WIDTH-1:0] m_tdata;              // parsed_value
    logic [2:0]           m_tuser;              // base_used, was_negative

    ascii_integer_stream_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    item_t        char_items[$];
    result_t      pending_values[$];
    item_t        next_char;
    result_t      want;

    logic         signed_copy = 1'b0;
    logic [2:0]   phase_now   = PH_LEAD;
    logic [63:0]  acc_now     = 64'd0;
    logic         minus_now   = 1'b0;
    logic [1:0]   base_now    = BASE_DEC;

    int           idle_pct       = 28;
    int           mismatches     = 0;
    int           quiet_cycles   = 0;
    int           queued_count   = 0;
    int           rx_hold_ticket = 0;
    int           rx_hold_seen   = 0;
    int           rx_hold_left   = 0;
    logic         in_taken       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB;
    endfunction

    task automatic start_number(input logic [7:0] c);
        if (c == CHAR_ZERO)
        begin
            phase_now = PH_ZERO;
            base_now  = BASE_OCT;
        end
        else if (c >= CHAR_ONE && c <= CHAR_NINE)
        begin
            phase_now = PH_DEC;
            acc_now   = {56'd0, c - CHAR_ZERO} & VALUE_MASK;
        end
        else
        begin
            phase_now = PH_DONE;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [63:0] digit;
        digit = 64'd0;
        case (phase_now)
            PH_LEAD:
            begin
                if (c == CHAR_MINUS)
                begin
                    minus_now = 1'b1;
                    phase_now = PH_MID;
                end
                else if (!is_blank(c))
                begin
                    start_number(c);
                end
            end
            PH_MID:
            begin
                if (!is_blank(c))
                    start_number(c);
            end
            PH_ZERO:
            begin
                if (c == CHAR_LOW_X || c == CHAR_UP_X)
                begin
                    phase_now = PH_HEX;
                    base_now  = BASE_HEX;
                end
                else if (c >= CHAR_ZERO && c <= CHAR_SEVEN)
                begin
                    phase_now = PH_OCT;
                    acc_now   = {56'd0, c - CHAR_ZERO} & VALUE_MASK;
                end
                else
                begin
                    phase_now = PH_DONE;
                end
            end
            PH_HEX:
            begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    digit = {56'd0, c - CHAR_ZERO};
                else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
                    digit = {56'd0, c - CHAR_LOW_A} + 64'd10;
                else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
                    digit = {56'd0, c - CHAR_UP_A} + 64'd10;
                else
                    phase_now = PH_DONE;
                if (phase_now == PH_HEX)
                    acc_now = ((acc_now << 4) | digit) & VALUE_MASK;
            end
            PH_OCT:
            begin
                if (c >= CHAR_ZERO && c <= CHAR_SEVEN)
                    acc_now = ((acc_now << 3) | {56'd0, c - CHAR_ZERO}) & VALUE_MASK;
                else
                    phase_now = PH_DONE;
            end
            PH_DEC:
            begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    acc_now = (acc_now * 64'd10 + {56'd0, c - CHAR_ZERO}) & VALUE_MASK;
                else
                    phase_now = PH_DONE;
            end
            default:
            begin
                phase_now = PH_DONE;
            end
        endcase
    endtask

    task automatic close_string();
        result_t r;
        r.was_negative = signed_copy && minus_now;
        r.parsed_value = r.was_negative ? ((64'd0 - acc_now) & VALUE_MASK) : acc_now;
        r.base_used    = base_now;
        pending_values.push_back(r);
        phase_now = PH_LEAD;
        acc_now   = 64'd0;
        minus_now = 1'b0;
        base_now  = BASE_DEC;
    endtask

    // input side: prediction, output side: checking, plus the watchdog
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata);
                if (s_tlast)
                    close_string();
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_values.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result value=%h user=%b", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (m_tdata !== want.parsed_value || m_tuser[1:0] !== want.base_used
                        || m_tuser[2] !== want.was_negative)
                    begin
                        if (mismatches < 10)
                            $display("mismatch value exp=%h got=%h base exp=%0d got=%0d neg exp=%b got=%b",
                                     want.parsed_value, m_tdata, want.base_used, m_tuser[1:0],
                                     want.was_negative, m_tuser[2]);
                        mismatches++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL ascii_integer_stream_parser");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (char_items.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                next_char = char_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_char.char_code;
                s_tlast  <= next_char.last_char;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_ticket != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_ticket;
            rx_hold_left <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic push_char(input logic [7:0] c, input logic last);
        item_t it;
        it.char_code = c;
        it.last_char = last;
        char_items.push_back(it);
        queued_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] blank_char();
        return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    function automatic logic [7:0] tricky_char();
        case ($urandom_range(8))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_MINUS;
            3: return CHAR_ZERO;
            4: return CHAR_LOW_X;
            5: return CHAR_UP_X;
            6: return CHAR_SEVEN;
            7: return CHAR_NINE;
            default: return CHAR_UP_F;
        endcase
    endfunction

    task automatic queue_random_string();
        logic [7:0] txt[$];
        int         n;
        int         d;
        if ($urandom_range(99) < 85)
        begin
            n = $urandom_range(3);
            repeat (n) txt.push_back(blank_char());
            if ($urandom_range(1))
            begin
                txt.push_back(CHAR_MINUS);
                if ($urandom_range(9) == 0)
                    txt.push_back(CHAR_MINUS);
            end
            n = $urandom_range(2);
            repeat (n) txt.push_back(blank_char());
            case ($urandom_range(2))
                0:
                begin
                    txt.push_back(CHAR_ONE + 8'($urandom_range(8)));
                    n = ($urandom_range(9) == 0) ? $urandom_range(26, 19) : $urandom_range(6);
                    repeat (n) txt.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                end
                1:
                begin
                    txt.push_back(CHAR_ZERO);
                    n = ($urandom_range(9) == 0) ? $urandom_range(24, 20) : $urandom_range(6);
                    repeat (n) txt.push_back(CHAR_ZERO + 8'($urandom_range(7)));
                end
                default:
                begin
                    txt.push_back(CHAR_ZERO);
                    txt.push_back($urandom_range(1) ? CHAR_LOW_X : CHAR_UP_X);
                    n = ($urandom_range(9) == 0) ? $urandom_range(20, 16) : $urandom_range(5);
                    repeat (n)
                    begin
                        d = $urandom_range(15);
                        if (d < 10)
                            txt.push_back(CHAR_ZERO + 8'(d));
                        else
                            txt.push_back(($urandom_range(1) ? CHAR_LOW_A : CHAR_UP_A)
                                          + 8'(d - 10));
                    end
                end
            endcase
            n = $urandom_range(3);
            repeat (n) txt.push_back(8'($urandom_range(255)));
        end
        else
        begin
            n = $urandom_range(6, 1);
            repeat (n) txt.push_back($urandom_range(1) ? 8'($urandom_range(255)) : tricky_char());
        end
        for (int i = 0; i < txt.size(); i++)
            push_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic wait_drained();
        while (char_items.size() > 0 || s_tvalid || pending_values.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_signed_mode(input logic mode);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = mode;
        signed_copy = mode;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    logic modes[6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // lead blanks and tab, hex with both cases, octal, lone zero,
        // bare prefix, double minus, no digits, extreme codes
        push_text("7");
        push_text(" \t-12");
        push_text("0x1aF");
        push_text("017");
        push_text("08");
        push_text("0X");
        push_text("--5");
        push_text("ab");
        push_char(8'hff, 1'b1);
        push_char(8'h00, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            write_signed_mode(modes[p]);
            idle_pct     = (p == 2) ? 0 : 28;
            queued_count = 0;
            while (queued_count < PHASE_ITEMS)
                queue_random_string();
            if (p == 3)
                rx_hold_ticket++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_values.size() == 0)
            $display("PASS ascii_integer_stream_parser");
        else
            $display("FAIL ascii_integer_stream_parser");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/aisp_pkg.sv
hdl/aisp_in_stage.sv
hdl/aisp_parser.sv
hdl/aisp_out_stage.sv
hdl/ascii_integer_stream_parser.sv
hdl/aisp_checker.sv
tb/tb_ascii_integer_stream_parser.sv
